/* rtl/hmd5_pkg.sv */
// Shared types, constants and MD5 round tables for the HMAC-MD5 engine.
package hmd5_pkg;

  typedef struct packed {
    logic       operation;
    logic [7:0] data_byte;
    logic       has_byte;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic [63:0] digest_half;
    logic        final_half;
  } out_item_t;

  localparam logic [7:0] IPAD = 8'h36;
  localparam logic [7:0] OPAD = 8'h5c;
  localparam int unsigned KEY_BYTES = 64;
  localparam int unsigned DIGEST_BYTES = 16;

  localparam logic [31:0] IV_A = 32'h67452301;
  localparam logic [31:0] IV_B = 32'hefcdab89;
  localparam logic [31:0] IV_C = 32'h98badcfe;
  localparam logic [31:0] IV_D = 32'h10325476;

  // Block source selection for the datapath buffer
  typedef enum logic [2:0] {
    SRC_NONE  = 3'd0,
    SRC_BYTE  = 3'd1,
    SRC_PADK  = 3'd2,
    SRC_ZERO  = 3'd3,
    SRC_LEN   = 3'd4,
    SRC_DIG   = 3'd5,
    SRC_KEYB  = 3'd6
  } src_t;

  // Controller to datapath commands
  typedef struct packed {
    logic       key_clear;     // zero key store
    logic       key_write;     // write byte into key store at key_length
    logic       key_from_dig;  // copy chain digest into key store
    logic       buf_write;     // write one buffer byte
    src_t       buf_src;
    logic [5:0] buf_pos;
    logic [7:0] pad;           // xor pad for SRC_PADK
    logic       chain_init;    // load IV
    logic       comp_start;    // start one compression
    logic       save_inner;    // latch inner digest
  } cmd_t;

  typedef struct packed {
    logic comp_busy;
  } stat_t;

  function automatic logic [31:0] sine_k(input logic [5:0] i);
    logic [31:0] t [64];
    t = '{32'hd76aa478,32'he8c7b756,32'h242070db,32'hc1bdceee,32'hf57c0faf,32'h4787c62a,
          32'ha8304613,32'hfd469501,32'h698098d8,32'h8b44f7af,32'hffff5bb1,32'h895cd7be,
          32'h6b901122,32'hfd987193,32'ha679438e,32'h49b40821,32'hf61e2562,32'hc040b340,
          32'h265e5a51,32'he9b6c7aa,32'hd62f105d,32'h02441453,32'hd8a1e681,32'he7d3fbc8,
          32'h21e1cde6,32'hc33707d6,32'hf4d50d87,32'h455a14ed,32'ha9e3e905,32'hfcefa3f8,
          32'h676f02d9,32'h8d2a4c8a,32'hfffa3942,32'h8771f681,32'h6d9d6122,32'hfde5380c,
          32'ha4beea44,32'h4bdecfa9,32'hf6bb4b60,32'hbebfbc70,32'h289b7ec6,32'heaa127fa,
          32'hd4ef3085,32'h04881d05,32'hd9d4d039,32'he6db99e5,32'h1fa27cf8,32'hc4ac5665,
          32'hf4292244,32'h432aff97,32'hab9423a7,32'hfc93a039,32'h655b59c3,32'h8f0ccc92,
          32'hffeff47d,32'h85845dd1,32'h6fa87e4f,32'hfe2ce6e0,32'ha3014314,32'h4e0811a1,
          32'hf7537e82,32'hbd3af235,32'h2ad7d2bb,32'heb86d391};
    return t[i];
  endfunction

  function automatic logic [4:0] rot_s(input logic [5:0] i);
    logic [4:0] t [16];
    t = '{5'd7,5'd12,5'd17,5'd22,5'd5,5'd9,5'd14,5'd20,
          5'd4,5'd11,5'd16,5'd23,5'd6,5'd10,5'd15,5'd21};
    return t[{i[5:4], i[1:0]}];
  endfunction

  // Message word index for round i
  function automatic logic [3:0] word_g(input logic [5:0] i);
    logic [3:0] g;
    unique case (i[5:4])
      2'd0: g = i[3:0];
      2'd1: g = 4'(5 * i[3:0] + 1);
      2'd2: g = 4'(3 * i[3:0] + 5);
      default: g = 4'(7 * i[3:0]);
    endcase
    return g;
  endfunction

endpackage

/* rtl/hmd5_datapath.sv */
// Key store, block buffer and iterative MD5 compression (one round per cycle).
module hmd5_datapath (
  input  logic               clk,
  input  logic               rst,
  input  hmd5_pkg::cmd_t     cmd,
  input  logic [7:0]         byte_in,
  input  logic [5:0]         key_pos,
  input  logic [63:0]        bit_length,
  output hmd5_pkg::stat_t    stat,
  output logic [127:0]       digest
);
  import hmd5_pkg::*;

  // key and block held as 16 little-endian words
  logic [31:0] key_mem [16];
  logic [31:0] blk [16];
  logic [31:0] chain [4];
  logic [31:0] inner [4];
  logic [31:0] a, b, c, d;
  logic [5:0]  round;
  logic        busy;
  logic [7:0]  wbyte;
  logic [31:0] f, t, m, rot, b_next;
  logic [3:0]  g;
  logic [4:0]  s;

  // Byte presented to the block buffer
  always_comb begin
    case (cmd.buf_src)
      SRC_BYTE: wbyte = byte_in;
      SRC_PADK: wbyte = key_mem[cmd.buf_pos[5:2]][8*cmd.buf_pos[1:0] +: 8] ^ cmd.pad;
      SRC_KEYB: wbyte = key_mem[cmd.buf_pos[5:2]][8*cmd.buf_pos[1:0] +: 8];
      SRC_LEN:  wbyte = bit_length[8*cmd.buf_pos[2:0] +: 8];
      SRC_DIG:  wbyte = inner[cmd.buf_pos[3:2]][8*cmd.buf_pos[1:0] +: 8];
      SRC_ZERO: wbyte = 8'h00;
      default:  wbyte = 8'h80;
    endcase
  end

  // One MD5 round
  always_comb begin
    unique case (round[5:4])
      2'd0: f = (b & c) | (~b & d);
      2'd1: f = (d & b) | (~d & c);
      2'd2: f = b ^ c ^ d;
      default: f = c ^ (b | ~d);
    endcase
    g = word_g(round);
    s = rot_s(round);
    m = blk[g];
    t = a + f + sine_k(round) + m;
    rot = (t << s) | (t >> (6'd32 - {1'b0, s}));
    b_next = b + rot;
  end

  // Key store
  always_ff @(posedge clk) begin
    if (rst || cmd.key_clear) begin
      for (int i = 0; i < 16; i++) key_mem[i] <= '0;
    end else if (cmd.key_from_dig) begin
      for (int i = 0; i < 4; i++) key_mem[i] <= chain[i];
      for (int i = 4; i < 16; i++) key_mem[i] <= '0;
    end else if (cmd.key_write) begin
      key_mem[key_pos[5:2]][8*key_pos[1:0] +: 8] <= byte_in;
    end
  end

  // Block buffer and inner digest
  always_ff @(posedge clk) begin
    if (cmd.buf_write) blk[cmd.buf_pos[5:2]][8*cmd.buf_pos[1:0] +: 8] <= wbyte;
    if (cmd.save_inner) for (int i = 0; i < 4; i++) inner[i] <= chain[i];
  end

  // Compression sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      round <= '0;
      chain <= '{IV_A, IV_B, IV_C, IV_D};
    end else if (cmd.chain_init) begin
      chain <= '{IV_A, IV_B, IV_C, IV_D};
    end else if (cmd.comp_start) begin
      busy <= 1'b1;
      round <= '0;
      a <= chain[0]; b <= chain[1]; c <= chain[2]; d <= chain[3];
    end else if (busy) begin
      a <= d; d <= c; c <= b; b <= b_next;
      round <= round + 6'd1;
      if (round == 6'd63) begin
        busy <= 1'b0;
        chain[0] <= chain[0] + d;
        chain[1] <= chain[1] + b_next;
        chain[2] <= chain[2] + b;
        chain[3] <= chain[3] + c;
      end
    end
  end

  assign stat.comp_busy = busy;
  always_comb
    for (int i = 0; i < 16; i++) digest[127-8*i -: 8] = chain[i/4][8*(i%4) +: 8];

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.comp_start |-> !busy) else $error("compression started while busy");
  a_no_write_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !cmd.buf_write) else $error("buffer written during compression");
  a_round_clear: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> $past(round) == 6'd63) else $error("compression ended early");
endmodule

/* rtl/hmd5_ctrl.sv */
// Sequencer for key intake, HMAC inner/outer passes, padding and output.
module hmd5_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  hmd5_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output hmd5_pkg::out_item_t out_item,
  output hmd5_pkg::cmd_t      cmd,
  input  hmd5_pkg::stat_t     stat,
  output logic [7:0]          byte_out,
  output logic [5:0]          key_pos,
  output logic [63:0]         bit_length,
  input  logic [127:0]        digest
);
  import hmd5_pkg::*;

  typedef enum logic [11:0] {
    S_IDLE  = 12'b000000000001,
    S_DISP  = 12'b000000000010, // route the pending transaction
    S_KLOAD = 12'b000000000100, // load key block into buffer
    S_GO    = 12'b000000001000, // issue compression
    S_COMP  = 12'b000000010000, // wait compression
    S_PAD80 = 12'b000000100000,
    S_PADZ  = 12'b000001000000,
    S_LEN   = 12'b000010000000,
    S_DIG   = 12'b000100000000, // feed inner digest to outer hash
    S_KDIG  = 12'b001000000000, // long key: copy digest into key store
    S_OUT0  = 12'b010000000000,
    S_OUT1  = 12'b100000000000
  } state_t;

  localparam logic [1:0] PH_IDLE = 2'd0, PH_KEY = 2'd1, PH_MSG = 2'd2;
  // What to do after a compression completes
  localparam logic [1:0] AF_DISP = 2'd0, AF_LOAD = 2'd1, AF_PADZ = 2'd2, AF_FIN = 2'd3;
  // Which key block is being loaded
  localparam logic [1:0] LD_SPILL = 2'd0, LD_INNER = 2'd1, LD_OUTER = 2'd2;

  state_t       state;
  logic [1:0]   phase;
  logic [6:0]   key_length;
  logic         key_long;
  logic [5:0]   pos;
  logic [1:0]   after;
  logic [1:0]   load_kind;
  logic         outer;     // 1 while hashing outer pass
  logic         pend_byte; // byte still to absorb
  logic         pend_last; // last flag still to handle
  logic         pend_msg;
  logic [7:0]   hold;
  logic [127:0] result;
  logic         absorb_now;
  logic         store_now;
  logic         spill_now;

  assign in_ready   = (state == S_IDLE);
  assign byte_out   = hold;
  assign key_pos    = key_length[5:0];
  assign out_valid  = (state == S_OUT0) || (state == S_OUT1);
  assign out_item.digest_half = (state == S_OUT0) ? result[127:64] : result[63:0];
  assign out_item.final_half  = (state == S_OUT1);

  // pending byte routing
  assign absorb_now = pend_byte && (pend_msg ? (phase == PH_MSG) : key_long);
  assign store_now  = pend_byte && !pend_msg && !key_long && !key_length[6];
  assign spill_now  = pend_byte && !pend_msg && !key_long && key_length[6];

  // Datapath commands
  always_comb begin
    cmd = '0;
    cmd.buf_pos = pos;
    cmd.pad = (load_kind == LD_OUTER) ? OPAD : IPAD;
    unique case (state)
      S_IDLE:  cmd.key_clear = in_valid && !in_item.operation && (phase != PH_KEY);
      S_DISP:  begin
        cmd.buf_pos = bit_length[8:3];
        cmd.buf_src = SRC_BYTE;
        cmd.buf_write = absorb_now;
        cmd.key_write = !absorb_now && store_now;
      end
      S_KLOAD: begin
        cmd.buf_write = 1'b1;
        cmd.buf_src = (load_kind == LD_SPILL) ? SRC_KEYB : SRC_PADK;
        cmd.chain_init = (pos == 6'd0);
      end
      S_PAD80: begin cmd.buf_write = 1'b1; cmd.buf_src = SRC_NONE; end
      S_PADZ:  begin cmd.buf_write = 1'b1; cmd.buf_src = SRC_ZERO; end
      S_LEN:   begin cmd.buf_write = 1'b1; cmd.buf_src = SRC_LEN; end
      S_DIG:   begin cmd.buf_write = 1'b1; cmd.buf_src = SRC_DIG; end
      S_GO:    cmd.comp_start = 1'b1;
      S_KDIG:  cmd.key_from_dig = 1'b1;
      // latch inner digest as the inner final block completes
      S_COMP:  cmd.save_inner = !stat.comp_busy && (after == AF_FIN) && !outer
                                && (phase == PH_MSG);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; phase <= PH_IDLE; key_length <= '0; key_long <= 1'b0;
      bit_length <= '0; pos <= '0; after <= AF_DISP; load_kind <= LD_INNER;
      outer <= 1'b0; pend_byte <= 1'b0; pend_last <= 1'b0; pend_msg <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: if (in_valid) begin
          hold <= in_item.data_byte;
          pend_byte <= in_item.has_byte;
          pend_last <= in_item.last;
          pend_msg <= in_item.operation;
          // a key transaction outside the key phase starts a fresh key
          if (!in_item.operation && phase != PH_KEY) begin
            phase <= PH_KEY; key_length <= '0; key_long <= 1'b0;
          end
          state <= S_DISP;
        end
        S_DISP: begin
          if (absorb_now) begin
            pend_byte <= 1'b0;
            bit_length <= bit_length + 64'd8;
            if (bit_length[8:3] == 6'd63) begin after <= AF_DISP; state <= S_GO; end
          end else if (store_now) begin
            pend_byte <= 1'b0;
            key_length <= key_length + 7'd1;
          end else if (spill_now) begin
            // 65th key byte: hash the 64 stored bytes first
            load_kind <= LD_SPILL; pos <= '0; state <= S_KLOAD;
          end else if (!pend_msg) begin
            if (pend_last) begin
              pend_last <= 1'b0;
              if (key_long) begin pos <= bit_length[8:3]; state <= S_PAD80; end
              else phase <= PH_IDLE;
            end else state <= S_IDLE;
          end else if (phase == PH_KEY) begin
            // message arrives with key open: close the key
            if (key_long) begin pos <= bit_length[8:3]; state <= S_PAD80; end
            else phase <= PH_IDLE;
          end else if (phase != PH_MSG) begin
            load_kind <= LD_INNER; pos <= '0; state <= S_KLOAD;
          end else if (pend_last) begin
            pend_last <= 1'b0; pos <= bit_length[8:3]; state <= S_PAD80;
          end else state <= S_IDLE;
        end
        S_KLOAD: begin
          pos <= pos + 6'd1;
          if (pos == 6'd63) begin after <= AF_LOAD; state <= S_GO; end
        end
        S_GO: state <= S_COMP;
        S_COMP: if (!stat.comp_busy) begin
          unique case (after)
            AF_DISP: state <= S_DISP;
            AF_PADZ: begin pos <= '0; state <= S_PADZ; end
            AF_LOAD: begin
              bit_length <= 64'd512;
              unique case (load_kind)
                LD_SPILL: begin key_long <= 1'b1; state <= S_DISP; end
                LD_INNER: begin phase <= PH_MSG; state <= S_DISP; end
                default:  begin pos <= '0; state <= S_DIG; end
              endcase
            end
            default: begin
              // final block of a digest finished
              if (phase == PH_KEY) state <= S_KDIG;
              else if (!outer) begin
                outer <= 1'b1; load_kind <= LD_OUTER; pos <= '0; state <= S_KLOAD;
              end else begin
                result <= digest; state <= S_OUT0;
              end
            end
          endcase
        end
        S_PAD80: begin
          if (pos == 6'd55) begin pos <= 6'd56; state <= S_LEN; end
          else if (pos == 6'd63) begin after <= AF_PADZ; state <= S_GO; end
          else begin pos <= pos + 6'd1; state <= S_PADZ; end
        end
        S_PADZ: begin
          if (pos == 6'd55) begin pos <= 6'd56; state <= S_LEN; end
          else if (pos == 6'd63) begin after <= AF_PADZ; state <= S_GO; end
          else pos <= pos + 6'd1;
        end
        S_LEN: begin
          pos <= pos + 6'd1;
          if (pos == 6'd63) begin after <= AF_FIN; state <= S_GO; end
        end
        S_DIG: begin
          pos <= pos + 6'd1;
          bit_length <= bit_length + 64'd8;
          if (pos == 6'd15) state <= S_PAD80;
        end
        S_KDIG: begin
          key_length <= 7'd16; key_long <= 1'b0; phase <= PH_IDLE; state <= S_DISP;
        end
        S_OUT0: if (out_ready) state <= S_OUT1;
        S_OUT1: if (out_ready) begin phase <= PH_IDLE; outer <= 1'b0; state <= S_IDLE; end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_out_order: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT1) |-> $past(state == S_OUT0 || state == S_OUT1))
    else $error("second half without first");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    stat.comp_busy |-> !in_ready) else $error("input taken during compression");
  a_wait: assert property (@(posedge clk) disable iff (rst)
    (state == S_GO) |=> stat.comp_busy) else $error("compression did not start");
endmodule

/* rtl/hmac_md5_engine.sv */
// HMAC-MD5 engine top level: controller plus MD5 datapath.
// One transaction at a time. A byte that completes a 64-byte block runs one MD5
// compression (64 rounds, one per cycle); the first message item after a key also
// hashes the key^0x36 block. A closing message item pads and runs the outer pass
// before the two halves; reset (rst, synchronous) empties the key and goes idle.
module hmac_md5_engine (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  hmd5_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output hmd5_pkg::out_item_t out_data
);
  import hmd5_pkg::*;

  cmd_t         cmd;
  stat_t        stat;
  logic [7:0]   byte_w;
  logic [5:0]   key_pos;
  logic [63:0]  bit_length;
  logic [127:0] digest;

  hmd5_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .in_item(in_data),
    .out_valid, .out_ready, .out_item(out_data),
    .cmd, .stat, .byte_out(byte_w), .key_pos, .bit_length, .digest
  );

  hmd5_datapath u_dp (
    .clk, .rst, .cmd, .byte_in(byte_w), .key_pos, .bit_length, .stat, .digest
  );
endmodule
